>>> design/tsr_pkg.sv
// Shared types, constants and helpers for the triangle scanline rasterizer.
// No dependencies; every other design file imports this package.
package tsr_pkg;

  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 8;
  localparam int TILE_SIZE = 64;
  localparam int FRAC_BITS = 16;

  // Edge accumulators and slopes: sign, one guard bit, integer and fraction.
  localparam int ACC_W     = COORD_W + FRAC_BITS + 2;
  // Divider dividend and quotient width: a 6-bit magnitude shifted by FRAC_BITS.
  localparam int DIV_W     = COORD_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  // Span counter holds up to TILE_SIZE rows.
  localparam int CNT_W     = COORD_W + 1;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] second_x;
    logic [COORD_W-1:0] second_y;
    logic [COORD_W-1:0] third_x;
    logic [COORD_W-1:0] third_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } tsr_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] span_row;
    logic [COORD_W-1:0] span_x_one;
    logic [COORD_W-1:0] span_x_two;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic [COLOR_W-1:0] out_alpha;
    logic               last_span;
  } tsr_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } vertex_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } color_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [COORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
    logic [COORD_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> design/tsr_sort.sv
// Vertex clamp and three-step compare-and-swap sort by y.
// Depends on tsr_pkg.
module tsr_sort (
  input  tsr_pkg::tsr_in_t tri_in,
  output tsr_pkg::vertex_t v_lo,
  output tsr_pkg::vertex_t v_mid,
  output tsr_pkg::vertex_t v_hi
);
  import tsr_pkg::*;

  function automatic logic [COORD_W-1:0] clamp_c(input logic [COORD_W-1:0] c);
    logic [COORD_W-1:0] r;
    r = c;
    if ({1'b0, c} > COORD_W'(TILE_SIZE - 1)) r = COORD_W'(TILE_SIZE - 1);
    return r;
  endfunction

  vertex_t a0, b0, c0, a1, c1, a2, b2, b3, c3;

  always_comb begin
    a0 = '{x: clamp_c(tri_in.first_x),  y: clamp_c(tri_in.first_y)};
    b0 = '{x: clamp_c(tri_in.second_x), y: clamp_c(tri_in.second_y)};
    c0 = '{x: clamp_c(tri_in.third_x),  y: clamp_c(tri_in.third_y)};
    // First with third.
    if (a0.y > c0.y) begin
      a1 = c0;
      c1 = a0;
    end else begin
      a1 = a0;
      c1 = c0;
    end
    // First with second.
    if (a1.y > b0.y) begin
      a2 = b0;
      b2 = a1;
    end else begin
      a2 = a1;
      b2 = b0;
    end
    // Second with third.
    if (b2.y > c1.y) begin
      b3 = c1;
      c3 = b2;
    end else begin
      b3 = b2;
      c3 = c1;
    end
  end

  assign v_lo  = a2;
  assign v_mid = b3;
  assign v_hi  = c3;

endmodule

>>> design/tsr_divider.sv
// Shared iterative restoring divider, one quotient bit per cycle.
// Depends on tsr_pkg.
module tsr_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  tsr_pkg::div_req_t req,
  output tsr_pkg::div_rsp_t rsp
);
  import tsr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     dvd_r;
  logic [COORD_W-1:0]   den_r;
  logic [COORD_W-1:0]   rem_r;

  logic [COORD_W:0] rem_sh;
  logic [COORD_W:0] rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIV_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
        dvd_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        // The quotient bit shifts in where the dividend bit left.
        dvd_r <= {dvd_r[DIV_W-2:0], ge};
        rem_r <= ge ? rem_sub[COORD_W-1:0] : rem_sh[COORD_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

>>> design/triangle_scanline_rasterizer.sv
// Triangle scanline rasterizer top level: sequencer, edge stepper, output register.
// Depends on tsr_pkg, tsr_sort and tsr_divider.
//
// Usage: a triangle request (three vertices and an RGBA color) is offered on
// in_valid/in_ready/in_data. It is taken only while the sequencer is idle. The
// triangle then produces one span request per covered row on out_valid/
// out_ready/out_data, with last_span set on the final one. Every triangle
// yields at least one span and at most 64.
// All slopes and the split point come from one shared divider that retires
// one quotient bit per cycle, and the sequencer waits for each division to
// finish. A flat-top or flat-bottom triangle needs at most two divisions
// (none when all three y are equal), a general triangle five (split point
// plus two slopes per half). Spans leave at one per cycle within each half
// while the receiver keeps out_ready high.
// The result sits in an output register. When the receiver stalls, the
// register holds its span and the edge stepper waits; nothing is lost. The
// next triangle may be accepted while the last span of the previous one is
// still waiting to be taken.
// Reset (rst_n low at a clock edge) returns the sequencer to idle, clears
// any pending divider work and drops out_valid.
module triangle_scanline_rasterizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsr_pkg::tsr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tsr_pkg::tsr_out_t out_data
);
  import tsr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SPLIT_DIV,
    S_SLOPE_L,
    S_SLOPE_R,
    S_EMIT
  } state_t;

  // Truncate a fixed-point edge position toward zero, keep the tile bits.
  function automatic logic [COORD_W-1:0] trunc_x(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sh;
    mag = (acc < 0) ? $unsigned(-acc) : $unsigned(acc);
    sh  = mag >> FRAC_BITS;
    if (acc < 0) sh = -sh;
    return sh[COORD_W-1:0];
  endfunction

  // Sorted vertices of the incoming request.
  vertex_t s_lo, s_mid, s_hi;

  tsr_sort u_sort (
    .tri_in (in_data),
    .v_lo   (s_lo),
    .v_mid  (s_mid),
    .v_hi   (s_hi)
  );

  // Shared divider.
  div_req_t div_req_r, div_req_nxt;
  div_rsp_t div_rsp;

  tsr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  state_t                   state_r, state_nxt;
  logic                     wait_r, wait_nxt;
  vertex_t                  v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  color_t                   color_r, color_nxt;
  logic                     single_r, single_nxt;
  logic                     top_r, top_nxt;
  logic                     num_neg_r, num_neg_nxt;
  logic [2*COORD_W:0]       num_mag_r, num_mag_nxt;
  logic [COORD_W-1:0]       mx_r, mx_nxt;
  logic signed [ACC_W-1:0]  step_l_r, step_l_nxt, step_r_r, step_r_nxt;
  logic signed [ACC_W-1:0]  acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic [COORD_W-1:0]       row_r, row_nxt;
  logic [CNT_W-1:0]         remain_r, remain_nxt;
  logic                     out_valid_r, out_valid_nxt;
  tsr_out_t                 out_data_r, out_data_nxt;

  // Geometry of the half being drawn. Both edges of a half share one height.
  logic [COORD_W-1:0]        dy_part;
  logic [COORD_W-1:0]        xl_a, xl_b, xr_a, xr_b;
  logic signed [COORD_W:0]   dx_l, dx_r, dx_sel;
  logic [COORD_W:0]          dx_abs;
  logic [COORD_W-1:0]        x_start;
  logic [COORD_W-1:0]        dy_split;
  logic signed [COORD_W:0]   dx_split;
  logic signed [2*COORD_W+1:0] prod;
  logic [2*COORD_W+1:0]      prod_abs;
  logic [ACC_W-1:0]          q_ext;
  logic signed [ACC_W-1:0]   slope_q;
  logic signed [COORD_W+1:0] q_s;
  logic signed [COORD_W+1:0] mx_sum;
  logic signed [ACC_W-1:0]   acc_init;
  logic                      final_part;
  logic                      out_free;
  logic                      slope_r_phase;

  always_comb begin
    // Bottom half runs from the top vertex down to the middle row; top half
    // runs from the bottom vertex up. Edge dx is the x at the larger y minus the x at the smaller y.
    if (!top_r) begin
      dy_part = v2_r.y - v1_r.y;
      xl_a    = v2_r.x;
      xl_b    = v1_r.x;
      xr_a    = single_r ? v3_r.x : mx_r;
      xr_b    = v1_r.x;
      x_start = v1_r.x;
    end else begin
      dy_part = single_r ? (v3_r.y - v1_r.y) : (v3_r.y - v2_r.y);
      xl_a    = v3_r.x;
      xl_b    = single_r ? v1_r.x : v2_r.x;
      xr_a    = v3_r.x;
      xr_b    = single_r ? v2_r.x : mx_r;
      x_start = v3_r.x;
    end
    dx_l     = $signed({1'b0, xl_a}) - $signed({1'b0, xl_b});
    dx_r     = $signed({1'b0, xr_a}) - $signed({1'b0, xr_b});
    slope_r_phase = (state_r == S_SLOPE_R);
    dx_sel   = slope_r_phase ? dx_r : dx_l;
    dx_abs   = (dx_sel < 0) ? $unsigned(-dx_sel) : $unsigned(dx_sel);

    // Signed quotient from the divider magnitude.
    q_ext    = ACC_W'(div_rsp.quotient);
    slope_q  = (dx_sel < 0) ? -$signed(q_ext) : $signed(q_ext);

    // Split point: x1 + floor((y2-y1)*(x3-x1)/(y3-y1)).
    dy_split = v2_r.y - v1_r.y;
    dx_split = $signed({1'b0, v3_r.x}) - $signed({1'b0, v1_r.x});
    prod     = $signed({1'b0, dy_split}) * dx_split;
    prod_abs = (prod < 0) ? $unsigned(-prod) : $unsigned(prod);
    q_s      = $signed({2'b00, div_rsp.quotient[COORD_W-1:0]});
    if (num_neg_r) begin
      q_s = -q_s;
      if (div_rsp.remainder != '0) q_s = q_s - (COORD_W+2)'(1);
    end
    mx_sum   = $signed({2'b00, v1_r.x}) + q_s;

    acc_init   = $signed({2'b00, x_start, {FRAC_BITS{1'b0}}});
    final_part = top_r || single_r;
    out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt     = state_r;
    wait_nxt      = wait_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    v3_nxt        = v3_r;
    color_nxt     = color_r;
    single_nxt    = single_r;
    top_nxt       = top_r;
    num_neg_nxt   = num_neg_r;
    num_mag_nxt   = num_mag_r;
    mx_nxt        = mx_r;
    step_l_nxt    = step_l_r;
    step_r_nxt    = step_r_r;
    acc_l_nxt     = acc_l_r;
    acc_r_nxt     = acc_r_r;
    row_nxt       = row_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req_nxt   = '{start: 1'b0, dividend: div_req_r.dividend,
                      divisor: div_req_r.divisor};

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v1_nxt     = s_lo;
          v2_nxt     = s_mid;
          v3_nxt     = s_hi;
          color_nxt  = '{red: in_data.red, green: in_data.green,
                         blue: in_data.blue, alpha: in_data.alpha};
          // Flat bottom draws only the lower half, flat top only the upper.
          single_nxt = (s_mid.y == s_hi.y) || (s_lo.y == s_mid.y);
          top_nxt    = (s_mid.y != s_hi.y) && (s_lo.y == s_mid.y);
          wait_nxt   = 1'b0;
          state_nxt  = ((s_mid.y == s_hi.y) || (s_lo.y == s_mid.y)) ? S_SLOPE_L : S_MUL;
        end
      end
      S_MUL: begin
        num_neg_nxt = (prod < 0);
        num_mag_nxt = prod_abs[2*COORD_W:0];
        state_nxt   = S_SPLIT_DIV;
      end
      S_SPLIT_DIV: begin
        if (!wait_r) begin
          div_req_nxt = '{start: 1'b1, dividend: DIV_W'(num_mag_r),
                          divisor: v3_r.y - v1_r.y};
          wait_nxt    = 1'b1;
        end else if (div_rsp.done) begin
          mx_nxt    = mx_sum[COORD_W-1:0];
          wait_nxt  = 1'b0;
          state_nxt = S_SLOPE_L;
        end
      end
      S_SLOPE_L, S_SLOPE_R: begin
        if (!wait_r && dy_part == '0) begin
          // Zero height edge: slope is zero.
          if (slope_r_phase) step_r_nxt = '0;
          else step_l_nxt = '0;
        end else if (!wait_r) begin
          div_req_nxt = '{start: 1'b1,
                          dividend: {dx_abs[COORD_W-1:0], {FRAC_BITS{1'b0}}},
                          divisor: dy_part};
          wait_nxt    = 1'b1;
        end else if (div_rsp.done) begin
          if (slope_r_phase) step_r_nxt = slope_q;
          else step_l_nxt = slope_q;
          wait_nxt = 1'b0;
        end
        // Advance once this edge's slope is settled.
        if ((!wait_r && dy_part == '0) || (wait_r && div_rsp.done)) begin
          if (slope_r_phase) begin
            acc_l_nxt  = acc_init;
            acc_r_nxt  = acc_init;
            row_nxt    = top_r ? v3_r.y : v1_r.y;
            remain_nxt = top_r ? {1'b0, dy_part} : ({1'b0, dy_part} + 1'b1);
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_SLOPE_R;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{span_row: row_r,
                            span_x_one: trunc_x(acc_l_r),
                            span_x_two: trunc_x(acc_r_r),
                            out_red: color_r.red, out_green: color_r.green,
                            out_blue: color_r.blue, out_alpha: color_r.alpha,
                            last_span: (remain_r == CNT_W'(1)) && final_part};
          if (top_r) begin
            acc_l_nxt = acc_l_r - step_l_r;
            acc_r_nxt = acc_r_r - step_r_r;
            row_nxt   = row_r - 1'b1;
          end else begin
            acc_l_nxt = acc_l_r + step_l_r;
            acc_r_nxt = acc_r_r + step_r_r;
            row_nxt   = row_r + 1'b1;
          end
          remain_nxt = remain_r - 1'b1;
          if (remain_r == CNT_W'(1)) begin
            if (final_part) begin
              state_nxt = S_IDLE;
            end else begin
              top_nxt   = 1'b1;
              wait_nxt  = 1'b0;
              state_nxt = S_SLOPE_L;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      wait_r          <= 1'b0;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      div_req_r   <= div_req_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      color_r     <= color_nxt;
      single_r    <= single_nxt;
      top_r       <= top_nxt;
      num_neg_r   <= num_neg_nxt;
      num_mag_r   <= num_mag_nxt;
      mx_r        <= mx_nxt;
      step_l_r    <= step_l_nxt;
      step_r_r    <= step_r_nxt;
      acc_l_r     <= acc_l_nxt;
      acc_r_r     <= acc_r_nxt;
      row_r       <= row_nxt;
      remain_r    <= remain_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/tb.sv
// Self-checking testbench for triangle_scanline_rasterizer.
// Depends on tsr_pkg and the design files. A scoreboard class predicts the
// spans of each triangle; plain tasks drive requests and a separate process stalls the receiver.
module tb;
  import tsr_pkg::*;

  // Fixed-point one for the edge accumulators.
  localparam longint FIX_ONE = longint'(1) << FRAC_BITS;
  // Cycles without any accepted request before the run is declared hung.
  // The slowest gap is a split triangle plus the longest sender gap and
  // receiver stall, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 3000;
  // Quiet cycles after the last expected span, to catch stray extra spans.
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_SHAPES = 400;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_FLAT_BOTTOM,
    PHASE_FLAT_TOP
  } fill_phase_t;

  // Span predictor and checker. It keeps its own copy of the edge stepper
  // state and queues the spans each accepted triangle must produce.
  class span_scoreboard;
    tsr_out_t    expected_spans[$];
    int          errors;
    logic [5:0]  cur_row;
    longint      left_acc;
    longint      right_acc;
    longint      left_slope;
    longint      right_slope;
    fill_phase_t phase;

    function new();
      errors      = 0;
      cur_row     = '0;
      left_acc    = 0;
      right_acc   = 0;
      left_slope  = 0;
      right_slope = 0;
      phase       = PHASE_IDLE;
    endfunction

    // Inverse slope dx/dy in fixed point, truncated toward zero. A flat edge
    // gets slope zero.
    function longint edge_slope(longint dx, longint dy);
      if (dy == 0) return 0;
      return (dx * FIX_ONE) / dy;
    endfunction

    // Integer x of an accumulator, truncated toward zero.
    function logic [5:0] span_end(longint acc);
      longint v;
      if (acc >= 0) v = acc >>> FRAC_BITS;
      else v = -((-acc) >>> FRAC_BITS);
      return v[5:0];
    endfunction

    function void order_by_y(inout vertex_t p, inout vertex_t r);
      vertex_t t;
      if (p.y > r.y) begin
        t = p;
        p = r;
        r = t;
      end
    endfunction

    // One flat part: count rows from y_start, stepping by dir.
    function void emit_part(color_t col, longint y_start, longint count, longint dir,
                            longint x_start, longint sl, longint sr);
      tsr_out_t span;
      longint   i;
      longint   row;
      left_slope  = sl;
      right_slope = sr;
      left_acc    = x_start * FIX_ONE;
      right_acc   = left_acc;
      for (i = 0; i < count; i++) begin
        row             = y_start + dir * i;
        cur_row         = row[5:0];
        span.span_row   = cur_row;
        span.span_x_one = span_end(left_acc);
        span.span_x_two = span_end(right_acc);
        span.out_red    = col.red;
        span.out_green  = col.green;
        span.out_blue   = col.blue;
        span.out_alpha  = col.alpha;
        span.last_span  = 1'b0;
        expected_spans.push_back(span);
        if (dir > 0) begin
          left_acc  += left_slope;
          right_acc += right_slope;
        end else begin
          left_acc  -= left_slope;
          right_acc -= right_slope;
        end
      end
    endfunction

    function void note_triangle(tsr_in_t shape);
      vertex_t a, b, c;
      color_t  col;
      longint  x1, y1, x2, y2, x3, y3;
      longint  num, den, q, mid_x;
      a.x = shape.first_x;
      a.y = shape.first_y;
      b.x = shape.second_x;
      b.y = shape.second_y;
      c.x = shape.third_x;
      c.y = shape.third_y;
      col.red   = shape.red;
      col.green = shape.green;
      col.blue  = shape.blue;
      col.alpha = shape.alpha;
      // Coordinates are six bits wide, so they never exceed the tile and
      // saturation has nothing to do.
      order_by_y(a, c);
      order_by_y(a, b);
      order_by_y(b, c);
      x1 = longint'(a.x);
      y1 = longint'(a.y);
      x2 = longint'(b.x);
      y2 = longint'(b.y);
      x3 = longint'(c.x);
      y3 = longint'(c.y);
      if (y2 == y3) begin
        phase = PHASE_FLAT_BOTTOM;
        emit_part(col, y1, y2 - y1 + 1, 1, x1,
                  edge_slope(x2 - x1, y2 - y1), edge_slope(x3 - x1, y3 - y1));
      end else if (y1 == y2) begin
        phase = PHASE_FLAT_TOP;
        emit_part(col, y3, y3 - y1, -1, x3,
                  edge_slope(x3 - x1, y3 - y1), edge_slope(x3 - x2, y3 - y2));
      end else begin
        // Split point on the long edge, with floor division.
        num = (y2 - y1) * (x3 - x1);
        den = y3 - y1;
        q   = num / den;
        if (num % den != 0 && num < 0) q--;
        mid_x = x1 + q;
        phase = PHASE_FLAT_BOTTOM;
        emit_part(col, y1, y2 - y1 + 1, 1, x1,
                  edge_slope(x2 - x1, y2 - y1), edge_slope(mid_x - x1, y2 - y1));
        phase = PHASE_FLAT_TOP;
        emit_part(col, y3, y3 - y2, -1, x3,
                  edge_slope(x3 - x2, y3 - y2), edge_slope(x3 - mid_x, y3 - y2));
      end
      // Every triangle yields at least one span, so the tail is its own.
      expected_spans[expected_spans.size() - 1].last_span = 1'b1;
      phase = PHASE_IDLE;
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_span(tsr_out_t got);
      tsr_out_t want;
      if (expected_spans.size() == 0) begin
        $display("%0t: unexpected span, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_spans.pop_front();
      if (got.span_row !== want.span_row)     report("span_row", want.span_row, got.span_row);
      if (got.span_x_one !== want.span_x_one) report("span_x_one", want.span_x_one, got.span_x_one);
      if (got.span_x_two !== want.span_x_two) report("span_x_two", want.span_x_two, got.span_x_two);
      if (got.out_red !== want.out_red)       report("out_red", want.out_red, got.out_red);
      if (got.out_green !== want.out_green)   report("out_green", want.out_green, got.out_green);
      if (got.out_blue !== want.out_blue)     report("out_blue", want.out_blue, got.out_blue);
      if (got.out_alpha !== want.out_alpha)   report("out_alpha", want.out_alpha, got.out_alpha);
      if (got.last_span !== want.last_span)   report("last_span", want.last_span, got.last_span);
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tsr_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tsr_out_t out_data;

  span_scoreboard sb = new();
  int burst_left = 0;

  triangle_scanline_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor. Both channels are sampled right after the edge, before any
  // nonblocking update of that step lands, so they show the values that the
  // edge itself saw. The span is checked before the new triangle is noted, so
  // a span can never match an expectation queued at the same edge.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) sb.check_span(out_data);
    if (rst_n && in_valid === 1'b1 && in_ready === 1'b1) sb.note_triangle(in_data);
  end

  // Watchdog: ends the run if neither channel moves a request for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid === 1'b1 && in_ready === 1'b1) ||
                    (out_valid === 1'b1 && out_ready === 1'b1)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Receiver. It switches between a few stall styles, each held for a random
  // stretch: always ready, coin flip, mostly stalled and strict alternation.
  initial begin
    int mode;
    int stretch;
    out_ready <= 1'b0;
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(10, 60);
      repeat (stretch) begin
        @(posedge clk);
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= ($urandom_range(0, 1) == 1);
          end
          2: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= ~out_ready;
          end
        endcase
      end
    end
  end

  function automatic tsr_in_t make_shape(int x1, int y1, int x2, int y2, int x3, int y3,
                                         logic [31:0] rgba);
    tsr_in_t s;
    s.first_x  = x1[5:0];
    s.first_y  = y1[5:0];
    s.second_x = x2[5:0];
    s.second_y = y2[5:0];
    s.third_x  = x3[5:0];
    s.third_y  = y3[5:0];
    {s.red, s.green, s.blue, s.alpha} = rgba;
    return s;
  endfunction

  // Offers one triangle and holds it until the block takes it. The caller
  // may offer the next one right away; valid then simply stays high.
  task automatic offer_triangle(tsr_in_t shape);
    in_data  <= shape;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Sender pacing: bursts of random length, usually separated by a random
  // gap with valid low, sometimes run back to back with no gap at all.
  task automatic send_triangle(tsr_in_t shape);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    offer_triangle(shape);
  endtask

  function automatic int near_coord(int base);
    int v;
    v = base + $urandom_range(0, 9);
    return (v > 63) ? 63 : v;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 62;
      default: return 63;
    endcase
  endfunction

  // Random triangle. Half are unrestricted; the rest are small triangles
  // (cheap to rasterize, dense in odd slopes), forced flat tops and bottoms,
  // fully flat ones or ones with evenly spaced x, and corners of the tile.
  function automatic tsr_in_t random_shape();
    tsr_in_t     s;
    logic [95:0] raw;
    int          bx, by;
    raw = {$urandom(), $urandom(), $urandom()};
    s   = raw[$bits(tsr_in_t)-1:0];
    bx  = $urandom_range(0, 63);
    by  = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      5, 6: begin
        s = make_shape(near_coord(bx), near_coord(by), near_coord(bx), near_coord(by),
                       near_coord(bx), near_coord(by), $urandom());
      end
      7: begin
        case ($urandom_range(0, 2))
          0: s.second_y = s.third_y;
          1: s.first_y  = s.second_y;
          default: s.first_y = s.third_y;
        endcase
      end
      8: begin
        if ($urandom_range(0, 1) == 0) begin
          s.second_y = s.first_y;
          s.third_y  = s.first_y;
        end else begin
          s = make_shape(bx, by, near_coord(bx), near_coord(by), near_coord(bx),
                         near_coord(by), $urandom());
          s.second_x = s.first_x + (s.second_y - s.first_y);
          s.third_x  = s.second_x + (s.second_y - s.first_y);
        end
      end
      9: begin
        s = make_shape(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                       edge_coord(), edge_coord(), $urandom());
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  initial begin
    int n;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed triangles.
    // Everything at zero, and everything at the tile's far corner: one span.
    send_triangle(make_shape(0, 0, 0, 0, 0, 0, 32'h00000000));
    send_triangle(make_shape(63, 63, 63, 63, 63, 63, 32'hffffffff));
    // All three y equal with different x: a single span at the first x.
    send_triangle(make_shape(10, 20, 40, 20, 5, 20, 32'haa55aa55));
    // Full tile height, split triangle: the maximum of 64 spans.
    send_triangle(make_shape(0, 0, 63, 32, 20, 63, 32'h55aa55aa));
    // Plain flat bottom and flat top, both edge directions.
    send_triangle(make_shape(30, 5, 0, 40, 63, 40, 32'h12345678));
    send_triangle(make_shape(0, 10, 63, 10, 32, 50, 32'h87654321));
    send_triangle(make_shape(63, 10, 0, 10, 5, 60, 32'hdeadbeef));
    send_triangle(make_shape(50, 0, 63, 45, 1, 45, 32'h0f0f0f0f));
    // Split triangles with the middle vertex on either side of the long edge.
    send_triangle(make_shape(10, 0, 60, 30, 5, 63, 32'hf0f0f0f0));
    send_triangle(make_shape(50, 2, 0, 20, 40, 60, 32'h01020304));
    // Long edge leaning left, so the split point needs floor division.
    send_triangle(make_shape(60, 0, 10, 20, 0, 63, 32'h80808080));
    // Vertical edge, and a degenerate collinear triangle.
    send_triangle(make_shape(20, 5, 20, 50, 40, 50, 32'h7f7f7f7f));
    send_triangle(make_shape(0, 0, 31, 31, 62, 62, 32'hc3c3c3c3));
    // Vertices given in falling y order, which the first-with-third swap alone puts in order.
    send_triangle(make_shape(5, 60, 30, 30, 50, 0, 32'h3c3c3c3c));
    // Ties in y between different vertex pairs, to pin down the swap order.
    send_triangle(make_shape(5, 10, 40, 50, 25, 10, 32'h11223344));
    send_triangle(make_shape(1, 40, 60, 40, 30, 0, 32'h44332211));
    send_triangle(make_shape(45, 30, 2, 8, 60, 30, 32'h99887766));
    // One-row-high triangles at the top and bottom of the tile.
    send_triangle(make_shape(0, 0, 63, 1, 30, 1, 32'h66778899));
    send_triangle(make_shape(0, 62, 63, 62, 10, 63, 32'hfedcba98));
    // Steep and shallow slopes into the corners.
    send_triangle(make_shape(63, 0, 0, 63, 63, 63, 32'h0055aaff));
    send_triangle(make_shape(0, 63, 63, 0, 0, 0, 32'hffaa5500));

    for (n = 0; n < RANDOM_SHAPES; n++) send_triangle(random_shape());
    in_valid <= 1'b0;

    // Wait for every predicted span, then watch a while for extra ones.
    while (sb.expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
